// ----- src/tli_pkg.sv -----
// Shared constants, types and codes for the table linear interpolator.
package tli_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int ENTRY_BITS  = 6;
   localparam int TABLE_DEPTH = 1 << ENTRY_BITS;
   localparam int CFG_BITS    = 7;
   localparam int CFG_RESET   = 64;
   localparam int CNT_BITS    = $clog2(VALUE_BITS + 1);

   typedef logic signed [VALUE_BITS-1:0] val_type;
   typedef logic signed [VALUE_BITS:0]   diff_type;
   typedef logic [VALUE_BITS-1:0]        mag_type;
   typedef logic [2*VALUE_BITS-1:0]      prod_type;
   typedef logic [ENTRY_BITS-1:0]        addr_type;

   localparam val_type VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam val_type VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INTERP     = 2'd0,
      STATUS_CLAMP_LOW  = 2'd1,
      STATUS_CLAMP_HIGH = 2'd2,
      STATUS_SPAN_FAULT = 2'd3
   } status_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic overflow;
   } div_status_type;

endpackage

// ----- src/tli_if.sv -----
// Channel interfaces: request, response and register write.
interface tli_req_if;
   logic                            valid;
   logic                            ready;
   logic                            action;
   logic [tli_pkg::ENTRY_BITS-1:0]  entry_index;
   tli_pkg::val_type                point_x;
   tli_pkg::val_type                point_y;
   tli_pkg::val_type                query_x;

   modport source (output valid, action, entry_index, point_x, point_y, query_x,
                   input ready);
   modport sink (input valid, action, entry_index, point_x, point_y, query_x,
                 output ready);
endinterface

interface tli_rsp_if;
   logic                 valid;
   logic                 ready;
   tli_pkg::val_type     result_y;
   tli_pkg::status_type  status;

   modport source (output valid, result_y, status, input ready);
   modport sink (input valid, result_y, status, output ready);
endinterface

interface tli_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tli_pkg::CFG_BITS-1:0]  points_in_use;

   modport source (output valid, points_in_use, input ready);
   modport sink (input valid, points_in_use, output ready);
endinterface

// ----- src/tli_table.sv -----
// Breakpoint memory: one write port, one registered read port, {x, y} per entry.
module tli_table (
   input  logic                                clock,
   input  logic                                wr_en,
   input  tli_pkg::addr_type                   wr_addr,
   input  logic [2*tli_pkg::VALUE_BITS-1:0]    wr_data,
   input  tli_pkg::addr_type                   rd_addr,
   output logic [2*tli_pkg::VALUE_BITS-1:0]    rd_data
);

   logic [2*tli_pkg::VALUE_BITS-1:0] entry_mem_ff [tli_pkg::TABLE_DEPTH];
   logic [2*tli_pkg::VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/tli_div.sv -----
// Restoring divider, one quotient bit per cycle, with up-front overflow check.
module tli_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  tli_pkg::prod_type        dividend,
   input  tli_pkg::mag_type         divisor,
   output tli_pkg::mag_type         quotient,
   output tli_pkg::div_status_type  sts
);

   localparam int VB = tli_pkg::VALUE_BITS;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic                      ovf_ff, ovf_in;
   logic [tli_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   tli_pkg::mag_type          rem_ff, rem_in;
   tli_pkg::mag_type          shq_ff, shq_in;
   tli_pkg::mag_type          dsr_ff, dsr_in;

   logic [VB:0] trial;
   logic [VB:0] trial_diff;
   logic        fits;

   // shared subtract/compare
   assign trial      = {rem_ff, shq_ff[VB-1]};
   assign trial_diff = trial - {1'b0, dsr_ff};
   assign fits       = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shq_in  = shq_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         dsr_in = divisor;
         rem_in = dividend[2*VB-1:VB];
         shq_in = dividend[VB-1:0];
         cnt_in = tli_pkg::CNT_BITS'(VB);
         // upper half at or above divisor: quotient needs more than VB bits
         if (dividend[2*VB-1:VB] >= divisor) begin
            ovf_in  = 1'b1;
            done_in = 1'b1;
         end else begin
            ovf_in  = 1'b0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = fits ? trial_diff[VB-1:0] : trial[VB-1:0];
         shq_in = {shq_ff[VB-2:0], fits};
         cnt_in = cnt_ff - tli_pkg::CNT_BITS'(1);
         if (cnt_ff == tli_pkg::CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ovf_ff <= ovf_in;
      rem_ff <= rem_in;
      shq_ff <= shq_in;
      dsr_ff <= dsr_in;
   end

   assign quotient     = shq_ff;
   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.overflow = ovf_ff;

endmodule

// ----- src/table_linear_interpolator.sv -----
// Top level: breakpoint table with binary search and linear interpolation.
//
//   channel   dir  handshake          payload
//   req_chan  in   valid/ready        action, entry_index, point_x, point_y, query_x
//   rsp_chan  out  valid/ready        result_y, status
//   csr_chan  in   valid/ready (=1)   points_in_use
//
// Write transfer: the entry lands in the memory at the accepting edge.
// Query: a low clamp is decided on the first table read, a high clamp on the second;
//   otherwise the time is set by the binary search over the single read port
//   (S_ISSUE and S_CMP per probe) and the one-bit-per-cycle divider (32 steps).
// Reset (synchronous) clears control state and sets points_in_use to 64.
// The table is not cleared; the user keeps it read only after being written (not enforced).
// A finished result sits in the output register; the next request is taken
// once the result has moved there, while rsp_chan stalls.
module table_linear_interpolator (
   input  logic       clock,
   input  logic       reset,
   tli_req_if.sink    req_chan,
   tli_rsp_if.source  rsp_chan,
   tli_csr_if.sink    csr_chan
);

   localparam int VB = tli_pkg::VALUE_BITS;
   localparam int AB = tli_pkg::ENTRY_BITS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOW,
      S_HIGH,
      S_ISSUE,
      S_CMP,
      S_LO,
      S_HI,
      S_MAG,
      S_MUL,
      S_DIVGO,
      S_DIVW,
      S_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic [tli_pkg::CFG_BITS-1:0] pts_ff, pts_in;
   tli_pkg::addr_type       last_ff, last_in;
   tli_pkg::addr_type       left_ff, left_in;
   tli_pkg::addr_type       right_ff, right_in;
   tli_pkg::addr_type       probe_ff, probe_in;
   tli_pkg::val_type        qx_ff, qx_in;
   tli_pkg::val_type        x0_ff, x0_in;
   tli_pkg::val_type        y0_ff, y0_in;
   tli_pkg::diff_type       span_ff, span_in;
   tli_pkg::diff_type       dy_ff, dy_in;
   tli_pkg::diff_type       dq_ff, dq_in;
   tli_pkg::mag_type        mag_span_ff, mag_span_in;
   tli_pkg::mag_type        mag_dy_ff, mag_dy_in;
   tli_pkg::mag_type        mag_dq_ff, mag_dq_in;
   logic                    neg_ff, neg_in;
   tli_pkg::prod_type       prod_ff, prod_in;
   tli_pkg::val_type        res_y_ff, res_y_in;
   tli_pkg::status_type     res_st_ff, res_st_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tli_pkg::val_type        rsp_y_ff, rsp_y_in;
   tli_pkg::status_type     rsp_st_ff, rsp_st_in;

   // table ports
   logic                    wr_en;
   tli_pkg::addr_type       rd_addr;
   logic [2*VB-1:0]         rd_data;
   tli_pkg::val_type        ent_x;
   tli_pkg::val_type        ent_y;

   // divider
   logic                    div_start;
   tli_pkg::mag_type        div_quot;
   tli_pkg::div_status_type div_sts;

   logic                    req_accept;
   logic [AB:0]             mid_sum;
   tli_pkg::addr_type       mid;
   logic signed [VB+1:0]    q_ext;
   logic signed [VB+1:0]    y0_ext;
   logic signed [VB+1:0]    sum_val;
   tli_pkg::val_type        interp_y;

   assign req_accept = req_chan.valid & req_chan.ready;
   assign wr_en      = req_accept & (req_chan.action == tli_pkg::ACTION_WRITE);

   assign ent_x = rd_data[2*VB-1:VB];
   assign ent_y = rd_data[VB-1:0];

   // upper midpoint of the live search window
   assign mid_sum = {1'b0, left_ff} + {1'b0, right_ff} + (AB+1)'(1);
   assign mid     = mid_sum[AB:1];

   tli_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_chan.entry_index),
      .wr_data ({req_chan.point_x, req_chan.point_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (mag_span_ff),
      .quotient (div_quot),
      .sts      (div_sts)
   );

   // y0 +/- quotient, saturated; quotient overflow saturates by sign
   assign q_ext   = signed'({2'b00, div_quot});
   assign y0_ext  = (VB+2)'(y0_ff);
   assign sum_val = neg_ff ? (y0_ext - q_ext) : (y0_ext + q_ext);

   always_comb begin
      if (div_sts.overflow) begin
         interp_y = neg_ff ? tli_pkg::VAL_MIN : tli_pkg::VAL_MAX;
      end else if (sum_val > (VB+2)'(tli_pkg::VAL_MAX)) begin
         interp_y = tli_pkg::VAL_MAX;
      end else if (sum_val < (VB+2)'(tli_pkg::VAL_MIN)) begin
         interp_y = tli_pkg::VAL_MIN;
      end else begin
         interp_y = sum_val[VB-1:0];
      end
   end

   // read address issued in the state before the one that uses the data
   always_comb begin
      case (state_ff)
         S_LOW:   rd_addr = last_ff;
         S_ISSUE: rd_addr = (left_ff < right_ff) ? mid : right_ff;
         S_LO:    rd_addr = right_ff + AB'(1);
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      pts_in       = pts_ff;
      last_in      = last_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      probe_in     = probe_ff;
      qx_in        = qx_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      span_in      = span_ff;
      dy_in        = dy_ff;
      dq_in        = dq_ff;
      mag_span_in  = mag_span_ff;
      mag_dy_in    = mag_dy_ff;
      mag_dq_in    = mag_dq_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      res_y_in     = res_y_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_st_in    = rsp_st_ff;
      div_start    = 1'b0;

      if (csr_chan.valid & csr_chan.ready) begin
         pts_in = csr_chan.points_in_use;
      end

      if (rsp_valid_ff & rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept & (req_chan.action == tli_pkg::ACTION_QUERY)) begin
               qx_in = req_chan.query_x;
               // zero counts as one point, beyond the table as the full table
               if (pts_ff == '0) begin
                  last_in = '0;
               end else if (pts_ff > tli_pkg::CFG_BITS'(tli_pkg::TABLE_DEPTH)) begin
                  last_in = AB'(tli_pkg::TABLE_DEPTH - 1);
               end else begin
                  last_in = AB'(pts_ff - tli_pkg::CFG_BITS'(1));
               end
               state_in = S_LOW;
            end
         end
         S_LOW: begin
            if (qx_ff <= ent_x) begin
               res_y_in  = ent_y;
               res_st_in = tli_pkg::STATUS_CLAMP_LOW;
               state_in  = S_OUT;
            end else begin
               state_in = S_HIGH;
            end
         end
         S_HIGH: begin
            if (qx_ff >= ent_x) begin
               res_y_in  = ent_y;
               res_st_in = tli_pkg::STATUS_CLAMP_HIGH;
               state_in  = S_OUT;
            end else begin
               left_in  = '0;
               right_in = last_ff;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (left_ff < right_ff) begin
               probe_in = mid;
               state_in = S_CMP;
            end else begin
               state_in = S_LO;
            end
         end
         S_CMP: begin
            if (ent_x <= qx_ff) begin
               left_in = probe_ff;
            end else begin
               right_in = probe_ff - AB'(1);
            end
            state_in = S_ISSUE;
         end
         S_LO: begin
            x0_in    = ent_x;
            y0_in    = ent_y;
            state_in = S_HI;
         end
         S_HI: begin
            span_in  = (VB+1)'(ent_x) - (VB+1)'(x0_ff);
            dy_in    = (VB+1)'(ent_y) - (VB+1)'(y0_ff);
            dq_in    = (VB+1)'(qx_ff) - (VB+1)'(x0_ff);
            state_in = S_MAG;
         end
         S_MAG: begin
            if (span_ff == '0) begin
               res_y_in  = y0_ff;
               res_st_in = tli_pkg::STATUS_SPAN_FAULT;
               state_in  = S_OUT;
            end else begin
               // spans of two VB-bit values have magnitudes that fit VB bits
               mag_span_in = VB'(span_ff[VB] ? -span_ff : span_ff);
               mag_dy_in   = VB'(dy_ff[VB] ? -dy_ff : dy_ff);
               mag_dq_in   = VB'(dq_ff[VB] ? -dq_ff : dq_ff);
               neg_in      = dy_ff[VB] ^ dq_ff[VB] ^ span_ff[VB];
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = mag_dy_ff * mag_dq_ff;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            div_start = 1'b1;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_sts.done) begin
               res_y_in  = interp_y;
               res_st_in = tli_pkg::STATUS_INTERP;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_y_in     = res_y_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pts_ff       <= tli_pkg::CFG_BITS'(tli_pkg::CFG_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pts_ff       <= pts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff     <= last_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      probe_ff    <= probe_in;
      qx_ff       <= qx_in;
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      span_ff     <= span_in;
      dy_ff       <= dy_in;
      dq_ff       <= dq_in;
      mag_span_ff <= mag_span_in;
      mag_dy_ff   <= mag_dy_in;
      mag_dq_ff   <= mag_dq_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      res_y_ff    <= res_y_in;
      res_st_ff   <= res_st_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_st_ff   <= rsp_st_in;
   end

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign csr_chan.ready    = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.result_y = rsp_y_ff;
   assign rsp_chan.status   = rsp_st_ff;

   // a new result only ever comes out of the hand-off state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside hand-off state");

   // no request taken while the divider is working
   a_no_req_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.busy |-> !req_chan.ready)
      else $error("request ready during division");

   // a probe only runs on a non-empty window
   a_probe_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (left_ff < right_ff))
      else $error("probe with empty search window");

   // divider start comes in the cycle after the product is taken
   a_div_after_mul: assert property (@(posedge clock) disable iff (reset)
      div_start |-> $past(state_ff == S_MUL))
      else $error("divider started without a fresh product");

endmodule
